// ----- sv/whsp_pkg.sv -----
// Package: shared types and constants of the WAV header stream parser.
package whsp_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_TAGS  = 3'd2,
    ST_FORMAT    = 3'd3,
    ST_OVERRUN   = 3'd4,
    ST_NO_DATA   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_CHANNELS = 2'd0,
    REG_RATE     = 2'd1,
    REG_BITS     = 2'd2,
    REG_MIN_LEN  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] channels;
    logic [31:0] rate_hz;
    logic [15:0] bits;
    logic [15:0] min_len;
  } cfg_t;

  localparam logic [15:0] RST_CHANNELS = 16'd1;
  localparam logic [31:0] RST_RATE     = 32'd16000;
  localparam logic [15:0] RST_BITS     = 16'd16;
  localparam logic [15:0] RST_MIN_LEN  = 16'd44;

  // Tags as little-endian words: byte k sits at bits [8k+7:8k].
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] POS_LIMIT   = 16'hFFFF;
  localparam logic [33:0] WALK_START  = 34'd36;
  localparam logic [33:0] HDR_BYTES   = 34'd8;
  localparam logic [31:0] FMT_PCM     = 32'd1;

endpackage

// ----- sv/whsp_in_if.sv -----
// Interface: byte stream input channel.
interface whsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- sv/whsp_out_if.sv -----
// Interface: parse result channel.
interface whsp_out_if;
  logic                 valid;
  logic                 ready;
  whsp_pkg::status_t    status;
  logic [15:0]          pcm_offset;
  logic [30:0]          sample_count;

  modport source (output valid, output status, output pcm_offset, output sample_count,
                  input ready);
  modport sink   (input valid, input status, input pcm_offset, input sample_count,
                  output ready);
endinterface

// ----- sv/wav_header_stream_parser.sv -----
// Top level: WAV header stream parser.
//
// Usage: feed the WAV buffer one byte per beat on in_bus, with last_byte set
// on the final byte. The block checks the RIFF and WAVE tags, the PCM format,
// channel, rate and bit fields against the configuration registers, walks the
// chunk headers from offset 36 and reports one result on out_bus per buffer:
// status, start offset of the PCM samples and the sample count.
// Throughput: one byte per cycle, except that a last byte waits while a
// result is held; limited by the single per-byte state update between the
// input register and the result register, which holds each buffer's result.
// Stall: while a result waits on out_bus, further non-last bytes keep
// flowing; a last byte holds in the input register until the result is taken.
// Reset: clears the stream state and loads the register defaults (channels 1,
// rate 16000, bits 16, minimum length 44). Program registers over the APB
// port only while no buffer is in flight.
module wav_header_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  whsp_in_if.sink     in_bus,
  whsp_out_if.source  out_bus,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import whsp_pkg::*;

  cfg_t cfg;

  whsp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  whsp_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.status == ST_OK) |-> (out_bus.pcm_offset >= 16'd44))
    else $error("ok result with pcm offset inside the fixed header");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.status != ST_OK) |->
      (out_bus.pcm_offset == 16'd0 && out_bus.sample_count == 31'd0))
    else $error("failed result carries non-zero fields");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (out_bus.valid && !out_bus.ready))
    else $error("input stalled without a blocked result");

endmodule

// ----- sv/whsp_cfg_regs.sv -----
// Configuration registers behind an APB-style port.
module whsp_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output whsp_pkg::cfg_t   cfg
);
  import whsp_pkg::*;

  logic [15:0] channels_r;
  logic [31:0] rate_r;
  logic [15:0] bits_r;
  logic [15:0] min_len_r;
  logic        wr_en;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r <= RST_CHANNELS;
      rate_r     <= RST_RATE;
      bits_r     <= RST_BITS;
      min_len_r  <= RST_MIN_LEN;
    end else if (wr_en) begin
      unique case (idx)
        REG_CHANNELS: channels_r <= pwdata[15:0];
        REG_RATE:     rate_r     <= pwdata;
        REG_BITS:     bits_r     <= pwdata[15:0];
        REG_MIN_LEN:  min_len_r  <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CHANNELS: prdata = {16'd0, channels_r};
      REG_RATE:     prdata = rate_r;
      REG_BITS:     prdata = {16'd0, bits_r};
      REG_MIN_LEN:  prdata = {16'd0, min_len_r};
    endcase
  end

  assign cfg.channels    = channels_r;
  assign cfg.rate_hz     = rate_r;
  assign cfg.bits        = bits_r;
  assign cfg.min_len     = min_len_r;

endmodule

// ----- sv/whsp_engine.sv -----
// Parse engine: input register, per-byte header state update, result register.
module whsp_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  whsp_pkg::cfg_t  cfg,
  whsp_in_if.sink         in_bus,
  whsp_out_if.source      out_bus
);
  import whsp_pkg::*;

  // input register
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic        advance;

  // stream state
  logic [15:0] pos_r,      pos_nxt;
  logic        tag_bad_r,  tag_bad_nxt;
  logic        fmt_bad_r,  fmt_bad_nxt;
  logic [31:0] acc_r,      acc_nxt;
  logic [33:0] chdr_r,     chdr_nxt;
  logic        id_data_r,  id_data_nxt;
  logic        found_r,    found_nxt;
  logic [31:0] dsize_r,    dsize_nxt;
  logic [33:0] dend_r,     dend_nxt;

  // result register
  logic        out_valid_r;
  status_t     status_r,   status_nxt;
  logic [15:0] pcm_r,      pcm_nxt;
  logic [30:0] count_r,    count_nxt;

  logic        take;
  logic [33:0] p_wide;
  logic [33:0] diff;
  logic        in_win;
  logic        fmt_en;
  logic [1:0]  fmt_k;
  logic        gather_en;
  logic [1:0]  gk;
  logic [31:0] acc_base;
  logic [31:0] acc_g;
  logic [15:0] min_len;

  assign advance      = in_valid_r && (!in_last_r || !out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      in_byte_r <= in_bus.data_byte;
      in_last_r <= in_bus.last_byte;
    end
  end

  assign take   = (pos_r != POS_LIMIT);
  assign p_wide = {18'd0, pos_r};
  assign diff   = p_wide - chdr_r;
  assign in_win = take && !found_r && (chdr_r <= p_wide) && (diff[33:3] == 31'd0);

  always_comb begin
    fmt_en = 1'b0;
    fmt_k  = 2'd0;
    priority if (pos_r >= 16'd20 && pos_r < 16'd24) begin
      fmt_en = 1'b1;
      fmt_k  = {1'b0, pos_r[0]};
    end else if (pos_r >= 16'd24 && pos_r < 16'd28) begin
      fmt_en = 1'b1;
      fmt_k  = pos_r[1:0];
    end else if (pos_r >= 16'd34 && pos_r < 16'd36) begin
      fmt_en = 1'b1;
      fmt_k  = {1'b0, pos_r[0]};
    end else begin
      fmt_en = 1'b0;
    end
  end

  assign gather_en = fmt_en || (in_win && diff[2]);
  assign gk        = fmt_en ? fmt_k : diff[1:0];
  assign acc_base  = (gk == 2'd0) ? 32'd0 : acc_r;
  assign acc_g     = acc_base | ({24'd0, in_byte_r} << {gk, 3'b000});

  always_comb begin
    pos_nxt     = take ? pos_r + 16'd1 : pos_r;
    tag_bad_nxt = tag_bad_r;
    fmt_bad_nxt = fmt_bad_r;
    acc_nxt     = gather_en ? acc_g : acc_r;
    chdr_nxt    = chdr_r;
    id_data_nxt = id_data_r;
    found_nxt   = found_r;
    dsize_nxt   = dsize_r;
    dend_nxt    = dend_r;

    if (pos_r < 16'd4) begin
      if (in_byte_r != TAG_RIFF[{pos_r[1:0], 3'b000} +: 8]) tag_bad_nxt = 1'b1;
    end
    if (pos_r >= 16'd8 && pos_r < 16'd12) begin
      if (in_byte_r != TAG_WAVE[{pos_r[1:0], 3'b000} +: 8]) tag_bad_nxt = 1'b1;
    end
    if (pos_r == 16'd21 && acc_g != FMT_PCM) fmt_bad_nxt = 1'b1;
    if (pos_r == 16'd23 && acc_g != {16'd0, cfg.channels}) fmt_bad_nxt = 1'b1;
    if (pos_r == 16'd27 && acc_g != cfg.rate_hz) fmt_bad_nxt = 1'b1;
    if (pos_r == 16'd35 && acc_g != {16'd0, cfg.bits}) fmt_bad_nxt = 1'b1;

    if (in_win && !diff[2]) begin
      if (in_byte_r != TAG_DATA[{diff[1:0], 3'b000} +: 8]) id_data_nxt = 1'b0;
    end
    if (in_win && diff[2:0] == 3'd7) begin
      if (id_data_r) begin
        found_nxt = 1'b1;
        dsize_nxt = acc_g;
        dend_nxt  = chdr_r + HDR_BYTES + {2'd0, acc_g};
      end else begin
        chdr_nxt    = chdr_r + {2'd0, acc_g} + (acc_g[0] ? HDR_BYTES + 34'd1 : HDR_BYTES);
        id_data_nxt = 1'b1;
      end
    end
  end

  assign min_len = (cfg.min_len < WALK_START[15:0]) ? WALK_START[15:0] : cfg.min_len;

  always_comb begin
    pcm_nxt   = 16'd0;
    count_nxt = 31'd0;
    priority if (pos_nxt < min_len) begin
      status_nxt = ST_SHORT;
    end else if (tag_bad_nxt) begin
      status_nxt = ST_BAD_TAGS;
    end else if (fmt_bad_nxt) begin
      status_nxt = ST_FORMAT;
    end else if (!found_nxt) begin
      status_nxt = ST_NO_DATA;
    end else if (dend_nxt > {18'd0, pos_nxt}) begin
      status_nxt = ST_OVERRUN;
    end else begin
      status_nxt = ST_OK;
      pcm_nxt    = chdr_r[15:0] + HDR_BYTES[15:0];
      count_nxt  = dsize_nxt[31:1];
    end
  end

  // Clear the stream state after the last beat of a buffer.
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && in_last_r)) begin
      pos_r     <= 16'd0;
      tag_bad_r <= 1'b0;
      fmt_bad_r <= 1'b0;
      acc_r     <= 32'd0;
      chdr_r    <= WALK_START;
      id_data_r <= 1'b1;
      found_r   <= 1'b0;
      dsize_r   <= 32'd0;
      dend_r    <= 34'd0;
    end else if (advance) begin
      pos_r     <= pos_nxt;
      tag_bad_r <= tag_bad_nxt;
      fmt_bad_r <= fmt_bad_nxt;
      acc_r     <= acc_nxt;
      chdr_r    <= chdr_nxt;
      id_data_r <= id_data_nxt;
      found_r   <= found_nxt;
      dsize_r   <= dsize_nxt;
      dend_r    <= dend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      status_r <= status_nxt;
      pcm_r    <= pcm_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.status       = status_r;
  assign out_bus.pcm_offset   = pcm_r;
  assign out_bus.sample_count = count_r;

endmodule

// ----- tb/tb_wav_header_stream_parser.sv -----
// Testbench: streams WAV buffers byte by byte into the header parser and checks every parse result.
module tb_wav_header_stream_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import whsp_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_LIST = 32'h5453_494C;

  typedef struct {
    status_t     status;
    logic [15:0] pcm_offset;
    logic [30:0] sample_count;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  whsp_in_if  in_bus();
  whsp_out_if out_bus();

  wav_header_stream_parser dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // register mirror
  logic [15:0] cfg_channels = RST_CHANNELS;
  logic [31:0] cfg_rate     = RST_RATE;
  logic [15:0] cfg_bits     = RST_BITS;
  logic [15:0] cfg_min_len  = RST_MIN_LEN;

  // parse state mirror
  int unsigned bytes_seen;
  bit          tags_bad;
  bit          fields_bad;
  bit          id_is_data;
  bit          data_seen;
  logic [31:0] field_word;
  logic [31:0] data_size;
  logic [63:0] chunk_at;

  parse_result_t expected_results[$];
  parse_result_t want;
  logic [7:0]    byte_q[$];
  int unsigned   bytes_sent;
  int            error_count;
  int            cycle_count;
  int            gap_pct;
  int            stall_pct;
  bit            hold_off_req;

  always #4 clk = ~clk;

  function automatic void restart_parse();
    bytes_seen = 0;
    tags_bad = 1'b0;
    fields_bad = 1'b0;
    field_word = '0;
    chunk_at = WALK_START;
    id_is_data = 1'b1;
    data_seen = 1'b0;
    data_size = '0;
  endfunction

  function automatic void collect(int unsigned k, logic [7:0] b);
    field_word = ((k == 0) ? 32'd0 : field_word) | (32'(b) << (8 * (k & 3)));
  endfunction

  function automatic void absorb(int unsigned p, logic [7:0] b);
    logic [63:0] pos;
    logic [63:0] r;
    pos = p;
    if (p < 4) begin
      if (b != TAG_RIFF[8*p +: 8]) tags_bad = 1'b1;
    end else if (p >= 8 && p < 12) begin
      if (b != TAG_WAVE[8*(p-8) +: 8]) tags_bad = 1'b1;
    end else if (p >= 20 && p < 24) begin
      collect((p - 20) & 1, b);
      if (p == 21 && field_word != FMT_PCM) fields_bad = 1'b1;
      if (p == 23 && field_word != {16'h0, cfg_channels}) fields_bad = 1'b1;
    end else if (p >= 24 && p < 28) begin
      collect(p - 24, b);
      if (p == 27 && field_word != cfg_rate) fields_bad = 1'b1;
    end else if (p >= 34 && p < 36) begin
      collect(p - 34, b);
      if (p == 35 && field_word != {16'h0, cfg_bits}) fields_bad = 1'b1;
    end
    if (!data_seen && pos >= chunk_at && pos < chunk_at + HDR_BYTES) begin
      r = pos - chunk_at;
      if (r < 4) begin
        if (b != TAG_DATA[8*r +: 8]) id_is_data = 1'b0;
      end else begin
        collect(32'(r - 4), b);
        if (r == 7) begin
          if (id_is_data) begin
            data_seen = 1'b1;
            data_size = field_word;
          end else begin
            chunk_at = chunk_at + HDR_BYTES + field_word + field_word[0];
            id_is_data = 1'b1;
          end
        end
      end
    end
  endfunction

  function automatic bit predict_parse(logic [7:0] b, logic last, output parse_result_t res);
    int unsigned min_len;
    logic [63:0] data_end;
    logic [63:0] offs;
    res.status = ST_OK;
    res.pcm_offset = '0;
    res.sample_count = '0;
    if (bytes_seen < POS_LIMIT) begin
      absorb(bytes_seen, b);
      bytes_seen++;
    end
    if (!last) return 1'b0;
    min_len = cfg_min_len;
    if (min_len < WALK_START) min_len = WALK_START;
    data_end = chunk_at + HDR_BYTES + data_size;
    offs = chunk_at + HDR_BYTES;
    if (bytes_seen < min_len) res.status = ST_SHORT;
    else if (tags_bad) res.status = ST_BAD_TAGS;
    else if (fields_bad) res.status = ST_FORMAT;
    else if (!data_seen) res.status = ST_NO_DATA;
    else if (data_end > bytes_seen) res.status = ST_OVERRUN;
    else begin
      res.pcm_offset = offs[15:0];
      res.sample_count = data_size[31:1];
    end
    restart_parse();
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3);
  endfunction

  function automatic void put_le(logic [31:0] value, int nbytes);
    int k;
    for (k = 0; k < nbytes; k++) byte_q.push_back(value[8*k +: 8]);
  endfunction

  function automatic void start_header(logic [15:0] fmt, logic [15:0] ch, logic [31:0] rate,
                                       logic [15:0] bits);
    byte_q.delete();
    put_le(TAG_RIFF, 4);
    put_le($urandom, 4);
    put_le(TAG_WAVE, 4);
    put_le(TAG_FMT, 4);
    put_le(32'd16, 4);
    put_le({16'h0, fmt}, 2);
    put_le({16'h0, ch}, 2);
    put_le(rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le({16'h0, bits}, 2);
  endfunction

  function automatic void good_header();
    start_header(FMT_PCM[15:0], cfg_channels, cfg_rate, cfg_bits);
  endfunction

  function automatic void add_chunk(logic [31:0] id, logic [31:0] size, int body);
    put_le(id, 4);
    put_le(size, 4);
    repeat (body) byte_q.push_back(8'($urandom));
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    parse_result_t res;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_bus.valid <= 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (predict_parse(b, last, res)) expected_results.push_back(res);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic ship_buffer();
    int i;
    for (i = 0; i < byte_q.size(); i++) send_byte(byte_q[i], i == byte_q.size() - 1);
    byte_q.delete();
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] held;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mask = 32'h0000_FFFF;
    case (idx)
      REG_CHANNELS: begin
        cfg_channels = value[15:0];
        held = {16'h0, cfg_channels};
      end
      REG_RATE: begin
        cfg_rate = value;
        held = cfg_rate;
        mask = 32'hFFFF_FFFF;
      end
      REG_BITS: begin
        cfg_bits = value[15:0];
        held = {16'h0, cfg_bits};
      end
      default: begin
        cfg_min_len = value[15:0];
        held = {16'h0, cfg_min_len};
      end
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== held) begin
      $error("register %s: expected %0h, got %0h", idx.name(), held, prdata & mask);
      error_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_config(logic [15:0] ch, logic [31:0] rate, logic [15:0] bits,
                              logic [15:0] min_len);
    cfg_write(REG_CHANNELS, {16'h0, ch});
    cfg_write(REG_RATE, rate);
    cfg_write(REG_BITS, {16'h0, bits});
    cfg_write(REG_MIN_LEN, {16'h0, min_len});
  endtask

  task automatic build_random_buffer();
    int n;
    int body;
    int cut;
    int pos;
    int pick;
    logic [31:0] id;
    logic [31:0] size;
    good_header();
    n = $urandom_range(0, 2);
    repeat (n) begin
      id = $urandom_range(0, 1) ? $urandom : TAG_DATA ^ (32'h1 << $urandom_range(0, 31));
      if (id == TAG_DATA) id = TAG_LIST;
      size = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 9);
      body = (size > 9) ? $urandom_range(0, 8) : size + size[0];
      add_chunk(id, size, body);
    end
    size = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 24);
    pick = $urandom_range(0, 9);
    if (size > 24) body = $urandom_range(0, 8);
    else if (pick < 7) body = size;
    else if (pick < 9) body = size + $urandom_range(1, 5);
    else body = $urandom_range(0, size);
    add_chunk(TAG_DATA, size, body);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      pos = $urandom_range(0, 7);
      if (pos > 3) pos += 4;
      byte_q[pos] ^= 8'($urandom_range(1, 255));
    end else if (pick < 16) begin
      pos = $urandom_range(0, 9);
      pos = (pos < 8) ? 20 + pos : 26 + pos;
      byte_q[pos] ^= 8'($urandom_range(1, 255));
    end else if (pick < 22) begin
      cut = $urandom_range(1, byte_q.size());
      byte_q = byte_q[0:cut-1];
    end else if (pick < 28) begin
      byte_q.delete();
      repeat ($urandom_range(1, 60)) byte_q.push_back(8'($urandom));
    end
  endtask

  task automatic test_default_config();
    gap_pct = 25;
    stall_pct = 25;
    good_header();
    add_chunk(TAG_DATA, 0, 0);
    ship_buffer();
    good_header();
    add_chunk(TAG_DATA, 5, 5);
    ship_buffer();
    good_header();
    add_chunk(TAG_LIST, 3, 4);
    add_chunk(TAG_DATA, 8, 8);
    ship_buffer();
  endtask

  task automatic test_status_cases();
    good_header();
    add_chunk(TAG_DATA, 0, 0);
    void'(byte_q.pop_back());
    ship_buffer();
    byte_q.push_back(8'hFF);
    ship_buffer();
    good_header();
    add_chunk(TAG_DATA, 2, 2);
    byte_q[0] ^= 8'h80;
    ship_buffer();
    good_header();
    add_chunk(TAG_DATA, 2, 2);
    byte_q[11] ^= 8'h01;
    ship_buffer();
    start_header(16'd3, cfg_channels, cfg_rate, cfg_bits);
    add_chunk(TAG_DATA, 2, 2);
    ship_buffer();
    start_header(FMT_PCM[15:0], 16'd2, cfg_rate, cfg_bits);
    add_chunk(TAG_DATA, 2, 2);
    ship_buffer();
    start_header(FMT_PCM[15:0], cfg_channels, 32'd16001, cfg_bits);
    add_chunk(TAG_DATA, 2, 2);
    ship_buffer();
    start_header(FMT_PCM[15:0], cfg_channels, cfg_rate, 16'd17);
    add_chunk(TAG_DATA, 2, 2);
    ship_buffer();
    good_header();
    add_chunk(TAG_DATA, 10, 9);
    ship_buffer();
    good_header();
    add_chunk(TAG_DATA, 32'hFFFF_FFFE, 4);
    ship_buffer();
    good_header();
    add_chunk(TAG_LIST, 2, 2);
    ship_buffer();
    good_header();
    add_chunk(TAG_LIST, 32'hFFFF_FFFF, 4);
    add_chunk(TAG_DATA, 0, 0);
    ship_buffer();
    good_header();
    add_chunk(TAG_DATA ^ 32'h0100_0000, 1, 2);
    add_chunk(TAG_DATA, 4, 4);
    ship_buffer();
    good_header();
    add_chunk(TAG_DATA, 0, 0);
    byte_q[0] ^= 8'h01;
    byte_q = byte_q[0:39];
    ship_buffer();
    good_header();
    add_chunk(TAG_DATA, 2, 2);
    byte_q[9] ^= 8'h10;
    byte_q[24] ^= 8'h01;
    ship_buffer();
    start_header(16'd0, cfg_channels, cfg_rate, cfg_bits);
    add_chunk(TAG_DATA, 50, 2);
    ship_buffer();
  endtask

  task automatic test_minimum_below_walk();
    wait_idle();
    apply_config(RST_CHANNELS, RST_RATE, RST_BITS, 16'd0);
    good_header();
    ship_buffer();
    good_header();
    void'(byte_q.pop_back());
    ship_buffer();
  endtask

  task automatic test_result_hold_off();
    wait_idle();
    apply_config(RST_CHANNELS, RST_RATE, RST_BITS, RST_MIN_LEN);
    gap_pct = 0;
    stall_pct = 0;
    hold_off_req = 1'b1;
    repeat (3) begin
      good_header();
      add_chunk(TAG_DATA, 8, 8 + $urandom_range(0, 4));
      ship_buffer();
    end
  endtask

  task automatic test_random_buffers();
    int phase;
    int buffers;
    int unsigned start_bytes;
    for (phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          apply_config(16'd2, 32'd44100, 16'd24, 16'd0);
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          apply_config(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd36);
          gap_pct = 30;
          stall_pct = 30;
        end
        2: begin
          apply_config(16'd0, 32'd0, 16'd0, 16'd40);
          gap_pct = 10;
          stall_pct = 60;
        end
        default: begin
          apply_config(16'($urandom), $urandom, 16'($urandom), 16'($urandom_range(36, 60)));
          gap_pct = 60;
          stall_pct = 10;
        end
      endcase
      start_bytes = bytes_sent;
      buffers = 0;
      while (bytes_sent - start_bytes < 60 || buffers < 1) begin
        build_random_buffer();
        ship_buffer();
        buffers++;
      end
    end
  endtask

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_bus.ready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no parse pending");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_bus.status);
          error_count++;
        end
        if (out_bus.pcm_offset !== want.pcm_offset) begin
          $error("pcm_offset: expected %0d, got %0d", want.pcm_offset, out_bus.pcm_offset);
          error_count++;
        end
        if (out_bus.sample_count !== want.sample_count) begin
          $error("sample_count: expected %0d, got %0d", want.sample_count,
                 out_bus.sample_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[wav_header_stream_parser] ERROR");
      $finish;
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.data_byte = '0;
    in_bus.last_byte = 1'b0;
    restart_parse();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_config();
    test_status_cases();
    test_minimum_below_walk();
    test_result_hold_off();
    test_random_buffers();
    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("[wav_header_stream_parser] OK");
    end else begin
      $display("[wav_header_stream_parser] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/whsp_pkg.sv
sv/whsp_in_if.sv
sv/whsp_out_if.sv
sv/whsp_cfg_regs.sv
sv/whsp_engine.sv
sv/wav_header_stream_parser.sv
tb/tb_wav_header_stream_parser.sv
